// File: design/assert_macros.svh
// Assertion macros used by the design file dns_name_label_encoder.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define AST_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/dnsle_pkg.sv
// Package for the DNS name label encoder: constants and result beat type.
`timescale 1ns / 1ps
`default_nettype none
package dnsle_pkg;

	localparam int unsigned MAX_NAME_BYTES = 256;
	// write_addr is 8 bits, so no more than 256 bytes can be addressed
	localparam int unsigned ADDR_SPAN = 256;
	localparam int unsigned CAP_LIMIT =
		(MAX_NAME_BYTES < ADDR_SPAN) ? MAX_NAME_BYTES : ADDR_SPAN;

	localparam logic [7:0] CH_END = 8'h00;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [8:0] CAP_MAX = 9'(CAP_LIMIT);
	localparam logic [8:0] CNT_SAT = 9'h1ff;

	// one output beat
	typedef struct packed {
		logic [7:0] write_addr;
		logic [7:0] write_byte;
		logic       write_enable;
		logic       run_last;
		logic       name_done;
		logic       overflow;
	} res_t;

endpackage
`default_nettype wire

// File: design/dns_name_label_encoder.sv
// DNS name label encoder: dotted name characters in, wire-form buffer writes out.
//
//  channel | dir | tdata / data            | tuser                          | tlast
//  --------+-----+-------------------------+--------------------------------+---------
//  s_*     | in  | [7:0] name_char         | -                              | -
//  m_*     | out | [7:0] addr, [15:8] byte | [0] wr_en, [1] done, [2] ovf   | run_last
//  cfg_*   | in  | [8:0] buffer_capacity   | -                              | -
//
// One character per cycle when the output is free: an input register feeds
// one pass of counter update and capacity compare into the result register.
// The end-of-name zero with a non-empty open label and no overflow gives two
// beats, so it holds the input stage while the second beat waits in ext_q;
// all other characters give one. Results leave through a two-entry output
// register pair; m_tready low stalls the pass and then s_tready.
// arst_n resets name state, clears valid flags and sets buffer_capacity to 256.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dns_name_label_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input characters
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] name_char
	// buffer writes
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] write_addr, [15:8] write_byte
	output logic [2:0]       m_tuser,   // [0] write_enable, [1] name_done, [2] overflow
	output logic             m_tlast,   // run_last
	// capacity register
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [8:0]  cfg_data
);
	import dnsle_pkg::*;

	logic [8:0] capacity_q;
	logic       in_valid_s1;
	logic [7:0] in_char_s1;
	logic [8:0] wpos_q;
	logic [7:0] lstart_q;
	logic [8:0] ccount_q;
	logic       err_q;
	res_t       out_q, ext_q;
	logic       out_valid_q, ext_valid_q;

	logic       out_free, fire;
	logic       is_end, is_dot, err_now, lbl_empty, two_beats;
	logic [8:0] cap_eff, cc_next;
	logic [9:0] need;
	logic [7:0] lbl_len;
	res_t       beat0, beat1;

	// handshakes
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || (m_tready && !ext_valid_q);
	assign fire      = in_valid_s1 && out_free;
	assign s_tready  = !in_valid_s1 || fire;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_char_s1 <= s_tdata;
		end
	end

	// encode pass
	always_comb begin
		is_end    = (in_char_s1 == CH_END);
		is_dot    = (in_char_s1 == CH_DOT);
		cap_eff   = (capacity_q > CAP_MAX) ? CAP_MAX : capacity_q;
		cc_next   = (is_end || ccount_q == CNT_SAT) ? ccount_q : ccount_q + 9'd1;
		need      = {1'b0, cc_next} + 10'd2;
		err_now   = err_q || (need > {1'b0, cap_eff});
		lbl_len   = 8'(wpos_q - {1'b0, lstart_q} - 9'd1);
		lbl_empty = (wpos_q == {1'b0, lstart_q} + 9'd1);
		two_beats = is_end && !err_now && !lbl_empty;

		beat0 = '{write_addr: 8'h00, write_byte: 8'h00, write_enable: 1'b0,
			run_last: 1'b1, name_done: is_end, overflow: 1'b1};
		beat1 = '{write_addr: wpos_q[7:0], write_byte: 8'h00, write_enable: 1'b1,
			run_last: 1'b1, name_done: 1'b1, overflow: 1'b0};

		if (!err_now) begin
			beat0.overflow     = 1'b0;
			beat0.write_enable = 1'b1;
			if (is_end) begin
				beat0.write_addr = lstart_q;
				beat0.write_byte = lbl_empty ? 8'h00 : lbl_len;
				beat0.run_last   = lbl_empty;
			end else if (is_dot) begin
				beat0.write_addr = lstart_q;
				beat0.write_byte = lbl_len;
			end else begin
				beat0.write_addr = wpos_q[7:0];
				beat0.write_byte = in_char_s1;
			end
		end
	end

	// name state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q   <= 9'd1;
			lstart_q <= 8'd0;
			ccount_q <= 9'd0;
			err_q    <= 1'b0;
		end else if (fire) begin
			if (is_end) begin
				wpos_q   <= 9'd1;
				lstart_q <= 8'd0;
				ccount_q <= 9'd0;
				err_q    <= 1'b0;
			end else begin
				ccount_q <= cc_next;
				err_q    <= err_now;
				if (!err_now) begin
					wpos_q <= wpos_q + 9'd1;
					if (is_dot) begin
						lstart_q <= wpos_q[7:0];
					end
				end
			end
		end
	end

	// output register pair: out_q is on the bus, ext_q holds a second beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ext_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
			ext_valid_q <= two_beats;
		end else if (out_valid_q && m_tready) begin
			if (ext_valid_q) begin
				ext_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= beat0;
			ext_q <= beat1;
		end else if (out_valid_q && m_tready && ext_valid_q) begin
			out_q <= ext_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.write_byte, out_q.write_addr};
	assign m_tuser  = {out_q.overflow, out_q.name_done, out_q.write_enable};
	assign m_tlast  = out_q.run_last;

	// checks
	`AST_IMPL(a_ext_needs_out, ext_valid_q, out_valid_q, "second beat without first")
	`AST_NEXT(a_ext_holds, ext_valid_q && !m_tready, ext_valid_q && out_valid_q,
		"second beat lost under stall")
	`AST_IMPL(a_nowrite_zero, m_tvalid && !m_tuser[0], m_tdata == 16'h0000,
		"non-write beat carries data")
	`AST_IMPL(a_ovf_nowrite, m_tvalid && m_tuser[2], !m_tuser[0] && m_tlast,
		"overflow beat carries a write")

endmodule
`default_nettype wire
